@@ src/ted_pkg.sv @@
// ----------------------------------------------------------------------------
// ted_pkg
// Types and constants for the text encoding detector: class codes and the
// byte patterns used by the byte order mark checks and the UTF-8 scan.
// ----------------------------------------------------------------------------
`default_nettype none

package ted_pkg;

   // Encoding class codes
   typedef enum logic [2:0] {
      CLS_UNKNOWN   = 3'd0,
      CLS_UTF16_LE  = 3'd1,
      CLS_UTF16_BE  = 3'd2,
      CLS_UTF8_BOM  = 3'd3,
      CLS_UTF8_NONE = 3'd4,
      CLS_ANSI      = 3'd5
   } encoding_class_type;

   // Byte order mark bytes
   localparam logic [7:0] BOM_FF = 8'hFF;
   localparam logic [7:0] BOM_FE = 8'hFE;
   localparam logic [7:0] BOM_EF = 8'hEF;
   localparam logic [7:0] BOM_BB = 8'hBB;
   localparam logic [7:0] BOM_BF = 8'hBF;

   // UTF-8 masks and match patterns
   localparam logic [7:0] MASK_TOP1  = 8'h80;
   localparam logic [7:0] MASK_TOP2  = 8'hC0;
   localparam logic [7:0] MASK_TOP3  = 8'hE0;
   localparam logic [7:0] MASK_TOP4  = 8'hF0;
   localparam logic [7:0] MASK_TOP5  = 8'hF8;
   localparam logic [7:0] PAT_CONT   = 8'h80;
   localparam logic [7:0] PAT_LEAD2  = 8'hC0;
   localparam logic [7:0] PAT_LEAD3  = 8'hE0;
   localparam logic [7:0] PAT_LEAD4  = 8'hF0;

   // Number of leading bytes kept for the mark checks
   localparam logic [1:0] LEAD_COUNT = 2'd3;

endpackage

`default_nettype wire

@@ src/text_encoding_detector_top.sv @@
// ----------------------------------------------------------------------------
// text_encoding_detector_top
// Classifies a byte stream as unknown, UTF-16 LE/BE, UTF-8 with or without a
// byte order mark, or ANSI, giving one class per buffer.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_valid / req_stall) carries one byte of the buffer
//   per request, with req_last_byte set on the final byte. Only the final
//   byte produces a response on rsp_valid / rsp_stall, carrying
//   rsp_encoding_class.
//   Throughput is one byte per clock while req_stall is low. The class is
//   registered on the final byte into the response or skid register.
//   Scan state sits in registers updated on each accepted byte; the class
//   is computed in the same cycle and captured in the response register.
//   When the receiver stalls, a finished response is held and the block keeps
//   taking bytes; a second finished response goes into a skid register, and
//   only then is req_stall raised until the response register drains.
//   Reset (synchronous, active high) clears all scan state and drops any
//   pending responses. All scan state also clears after each final byte.
// ----------------------------------------------------------------------------
`default_nettype none

module text_encoding_detector_top
   import ted_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_last_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [2:0]      rsp_encoding_class
);

   // Scan state
   logic [1:0] bytes_seen_ff, bytes_seen_in;
   logic [7:0] lead0_ff, lead0_in;
   logic [7:0] lead1_ff, lead1_in;
   logic [7:0] lead2_ff, lead2_in;
   logic [1:0] pending_ff, pending_in;
   logic       saw_high_ff, saw_high_in;
   logic       failed_ff, failed_in;

   // Response register and skid stage
   logic               rsp_valid_ff, rsp_valid_in;
   encoding_class_type rsp_class_ff, rsp_class_in;
   logic               skid_valid_ff, skid_valid_in;
   encoding_class_type skid_class_ff, skid_class_in;

   logic               req_take;
   logic               rsp_take;
   logic               result_now;
   logic [1:0]         cnt_upd;
   logic [7:0]         b0_upd, b1_upd, b2_upd;
   logic [1:0]         pend_upd;
   logic               high_upd, fail_upd, fail_end;
   encoding_class_type class_now;

   assign req_stall  = skid_valid_ff;
   assign req_take   = req_valid & ~skid_valid_ff;
   assign rsp_take   = rsp_valid_ff & ~rsp_stall;
   assign result_now = req_take & req_last_byte;

   // Leading byte capture and UTF-8 scan for the incoming byte
   always_comb begin
      cnt_upd  = bytes_seen_ff;
      b0_upd   = lead0_ff;
      b1_upd   = lead1_ff;
      b2_upd   = lead2_ff;
      pend_upd = pending_ff;
      high_upd = saw_high_ff;
      fail_upd = failed_ff;

      if (bytes_seen_ff < LEAD_COUNT) begin
         unique case (bytes_seen_ff)
            2'd0:    b0_upd = req_data_byte;
            2'd1:    b1_upd = req_data_byte;
            default: b2_upd = req_data_byte;
         endcase
         cnt_upd = bytes_seen_ff + 2'd1;
      end

      if (pending_ff != 2'd0) begin
         // continuation owed
         if ((req_data_byte & MASK_TOP2) != PAT_CONT) begin
            fail_upd = 1'b1;
         end
         pend_upd = pending_ff - 2'd1;
      end else if ((req_data_byte & MASK_TOP1) != 8'd0) begin
         high_upd = 1'b1;
         priority if ((req_data_byte & MASK_TOP3) == PAT_LEAD2) begin
            pend_upd = 2'd1;
         end else if ((req_data_byte & MASK_TOP4) == PAT_LEAD3) begin
            pend_upd = 2'd2;
         end else if ((req_data_byte & MASK_TOP5) == PAT_LEAD4) begin
            pend_upd = 2'd3;
         end else begin
            fail_upd = 1'b1;
         end
      end
   end

   // Class decision on the final byte
   always_comb begin
      fail_end = fail_upd | (pend_upd != 2'd0);
      priority if (cnt_upd < LEAD_COUNT) begin
         class_now = CLS_UNKNOWN;
      end else if (b0_upd == BOM_FF && b1_upd == BOM_FE) begin
         class_now = CLS_UTF16_LE;
      end else if (b0_upd == BOM_FE && b1_upd == BOM_FF) begin
         class_now = CLS_UTF16_BE;
      end else if (b0_upd == BOM_EF && b1_upd == BOM_BB && b2_upd == BOM_BF) begin
         class_now = CLS_UTF8_BOM;
      end else if (!fail_end && high_upd) begin
         class_now = CLS_UTF8_NONE;
      end else begin
         class_now = CLS_ANSI;
      end
   end

   // Next scan state: update on each byte, clear after the final one
   always_comb begin
      bytes_seen_in = bytes_seen_ff;
      lead0_in      = lead0_ff;
      lead1_in      = lead1_ff;
      lead2_in      = lead2_ff;
      pending_in    = pending_ff;
      saw_high_in   = saw_high_ff;
      failed_in     = failed_ff;
      if (req_take) begin
         if (req_last_byte) begin
            bytes_seen_in = 2'd0;
            lead0_in      = 8'd0;
            lead1_in      = 8'd0;
            lead2_in      = 8'd0;
            pending_in    = 2'd0;
            saw_high_in   = 1'b0;
            failed_in     = 1'b0;
         end else begin
            bytes_seen_in = cnt_upd;
            lead0_in      = b0_upd;
            lead1_in      = b1_upd;
            lead2_in      = b2_upd;
            pending_in    = pend_upd;
            saw_high_in   = high_upd;
            failed_in     = fail_upd;
         end
      end
   end

   // Response register with skid stage
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_class_in  = rsp_class_ff;
      skid_valid_in = skid_valid_ff;
      skid_class_in = skid_class_ff;
      if (!rsp_valid_ff || rsp_take) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_class_in  = skid_class_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = result_now;
            rsp_class_in = class_now;
         end
      end else if (result_now) begin
         skid_valid_in = 1'b1;
         skid_class_in = class_now;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff <= 2'd0;
         lead0_ff      <= 8'd0;
         lead1_ff      <= 8'd0;
         lead2_ff      <= 8'd0;
         pending_ff    <= 2'd0;
         saw_high_ff   <= 1'b0;
         failed_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         bytes_seen_ff <= bytes_seen_in;
         lead0_ff      <= lead0_in;
         lead1_ff      <= lead1_in;
         lead2_ff      <= lead2_in;
         pending_ff    <= pending_in;
         saw_high_ff   <= saw_high_in;
         failed_ff     <= failed_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rsp_class_ff  <= rsp_class_in;
      skid_class_ff <= skid_class_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_encoding_class = rsp_class_ff;

endmodule

`default_nettype wire

@@ test/text_encoding_detector_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_encoding_detector_top_tb
// Drives byte buffers into the encoding detector and checks every class it
// returns against a cycle-free predictor of the same decision order. The run
// starts with short directed buffers, then sends random ones under several
// sender and receiver idling patterns. Most random buffers are well-formed
// UTF-8 or carry a mark; the rest are broken sequences and noise.
// ----------------------------------------------------------------------------

module text_encoding_detector_top_tb;
   import ted_pkg::*;

   // Clock, reset and DUT ports
   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_encoding_class;

   // Idling control, percent of cycles
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   // Predictor state
   logic [1:0] bytes_taken = 2'd0;
   logic [7:0] lead_bytes [3];
   logic [1:0] conts_owed = 2'd0;
   logic       high_seen = 1'b0;
   logic       utf8_broken = 1'b0;

   // Expected classes, oldest first
   encoding_class_type expected_classes [$];

   // Buffer under construction
   logic [7:0] text_q [$];

   // Bookkeeping
   int mismatches = 0;
   int bytes_sent = 0;
   int buffers_checked = 0;
   int class_counts [6];

   always #6 clock = ~clock;

   text_encoding_detector_top DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_encoding_class (rsp_encoding_class)
   );

   // Return all scan state to its idle values
   task automatic clear_scan();
      bytes_taken = 2'd0;
      lead_bytes = '{8'h00, 8'h00, 8'h00};
      conts_owed = 2'd0;
      high_seen = 1'b0;
      utf8_broken = 1'b0;
   endtask

   // Fold one accepted byte into the scan; on the final byte, queue the class
   task automatic classify_byte(input logic [7:0] b, input logic last);
      encoding_class_type cls;
      if (bytes_taken < LEAD_COUNT) begin
         lead_bytes[bytes_taken] = b;
         bytes_taken = bytes_taken + 2'd1;
      end
      // UTF-8 scan: owed continuations first, then lead bytes
      if (conts_owed != 2'd0) begin
         if ((b & MASK_TOP2) != PAT_CONT) utf8_broken = 1'b1;
         conts_owed = conts_owed - 2'd1;
      end else if ((b & MASK_TOP1) != 8'h00) begin
         high_seen = 1'b1;
         if ((b & MASK_TOP3) == PAT_LEAD2) conts_owed = 2'd1;
         else if ((b & MASK_TOP4) == PAT_LEAD3) conts_owed = 2'd2;
         else if ((b & MASK_TOP5) == PAT_LEAD4) conts_owed = 2'd3;
         else utf8_broken = 1'b1;
      end
      if (last) begin
         // a sequence cut short by the end of the buffer fails the scan
         if (conts_owed != 2'd0) utf8_broken = 1'b1;
         if (bytes_taken < LEAD_COUNT)
            cls = CLS_UNKNOWN;
         else if (lead_bytes[0] == BOM_FF && lead_bytes[1] == BOM_FE)
            cls = CLS_UTF16_LE;
         else if (lead_bytes[0] == BOM_FE && lead_bytes[1] == BOM_FF)
            cls = CLS_UTF16_BE;
         else if (lead_bytes[0] == BOM_EF && lead_bytes[1] == BOM_BB &&
                  lead_bytes[2] == BOM_BF)
            cls = CLS_UTF8_BOM;
         else if (!utf8_broken && high_seen)
            cls = CLS_UTF8_NONE;
         else
            cls = CLS_ANSI;
         expected_classes.push_back(cls);
         clear_scan();
      end
   endtask

   // Send one byte as a request and wait for it to be taken
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      classify_byte(b, last);
      bytes_sent++;
   endtask

   // Send the whole of text_q as one buffer
   task automatic send_text();
      for (int i = 0; i < text_q.size(); i++)
         send_byte(text_q[i], i == text_q.size() - 1);
   endtask

   // Append one well-formed UTF-8 character with random content
   task automatic add_utf8_char();
      int len;
      len = $urandom_range(1, 4);
      case (len)
         1: text_q.push_back(8'($urandom_range(0, 127)));
         2: text_q.push_back(PAT_LEAD2 | 8'($urandom_range(0, 31)));
         3: text_q.push_back(PAT_LEAD3 | 8'($urandom_range(0, 15)));
         default: text_q.push_back(PAT_LEAD4 | 8'($urandom_range(0, 7)));
      endcase
      repeat (len - 1) text_q.push_back(PAT_CONT | 8'($urandom_range(0, 63)));
   endtask

   // Build a random buffer: marks, well-formed text, broken text or noise
   task automatic build_random_text();
      int kind;
      int chars;
      kind = $urandom_range(99);
      chars = ($urandom_range(9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 8);
      text_q = {};
      if (kind < 15) begin
         case ($urandom_range(2))
            0: text_q = {BOM_FF, BOM_FE};
            1: text_q = {BOM_FE, BOM_FF};
            default: text_q = {BOM_EF, BOM_BB, BOM_BF};
         endcase
         repeat ($urandom_range(0, 6)) add_utf8_char();
      end else if (kind < 85) begin
         repeat (chars) add_utf8_char();
         // broken variant: cut the tail or corrupt one byte
         if (kind >= 65) begin
            if (text_q.size() > 1 && $urandom_range(1) == 0)
               void'(text_q.pop_back());
            else
               text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom_range(0, 255));
         end
      end else begin
         repeat ($urandom_range(1, 10)) text_q.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   // Response checker and receiver stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_classes.size() == 0) begin
               $display("%0t: unexpected response, expected none, got class %0d",
                        $time, rsp_encoding_class);
               mismatches++;
            end else begin
               if (rsp_encoding_class !== expected_classes[0]) begin
                  $display("%0t: class mismatch, expected %0d, got %0d",
                           $time, expected_classes[0], rsp_encoding_class);
                  mismatches++;
               end
               class_counts[int'(expected_classes[0])]++;
               buffers_checked++;
               void'(expected_classes.pop_front());
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Buffers of one and two bytes, including a bare mark
   task automatic test_short_buffers();
      text_q = {8'hFF};
      send_text();
      text_q = {BOM_FE, BOM_FF};
      send_text();
   endtask

   // Byte order marks, and a near miss that falls through to the scan
   task automatic test_byte_order_marks();
      text_q = {BOM_FF, BOM_FE, 8'h00};
      send_text();
      text_q = {BOM_FE, BOM_FF, 8'h41};
      send_text();
      text_q = {BOM_EF, BOM_BB, BOM_BF};
      send_text();
      text_q = {BOM_EF, BOM_BB, 8'hBE};
      send_text();
   endtask

   // Scan outcomes: valid leads, cut-short tail, bad continuation, plain ASCII
   task automatic test_utf8_scan();
      text_q = {8'hC3, 8'hA9, 8'h7F};
      send_text();
      text_q = {8'hF0, 8'h9F, 8'h98, 8'h80};
      send_text();
      text_q = {8'h41, 8'hE2, 8'h82};
      send_text();
      text_q = {8'h00, 8'hC3, 8'h41};
      send_text();
      text_q = {8'h41, 8'h42, 8'h43};
      send_text();
   endtask

   // Random buffers under one idling pattern until the byte budget is spent
   task automatic test_random_traffic(input int send_pct, input int stall_pct,
                                      input int byte_budget);
      int start_bytes;
      send_idle_pct = send_pct;
      recv_stall_pct = stall_pct;
      start_bytes = bytes_sent;
      while (bytes_sent - start_bytes < byte_budget) begin
         build_random_text();
         send_text();
      end
   endtask

   // Test sequence
   initial begin
      clear_scan();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_short_buffers();
      test_byte_order_marks();
      test_utf8_scan();
      test_random_traffic(0, 0, 175);
      test_random_traffic(68, 0, 175);
      test_random_traffic(0, 68, 175);
      test_random_traffic(13, 13, 175);
      req_valid <= 1'b0;

      // drain outstanding responses, then allow for the output register
      while (expected_classes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Summary: %0d bytes in %0d buffers under four idling patterns",
               bytes_sent, buffers_checked);
      $display("Classes: unknown %0d, utf16 le %0d, utf16 be %0d, utf8 bom %0d, %s%0d, ansi %0d",
               class_counts[0], class_counts[1], class_counts[2], class_counts[3],
               "utf8 plain ", class_counts[4], class_counts[5]);
      if (mismatches == 0) begin
         $display("text_encoding_detector_top verification clean");
      end else begin
         $display("text_encoding_detector_top verification failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5000000;
      $display("%0t: timeout with %0d responses outstanding", $time,
               expected_classes.size());
      $display("text_encoding_detector_top verification failed");
      $finish;
   end

endmodule
